FILE: rtl/bellman_ford_shortest_paths_assert.svh
// Assertion macros used by the checker file of the shortest-path block.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bfsp_pkg.sv
// Shared constants, codes and types of the shortest-path block.
`default_nettype none

package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VTX_W     = 4;   // vertex, row, col and source fields
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_W    = 21;
  localparam int VC_W      = 5;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_RUN   = 1'b1
  } cmd_e;

  // Control of the read-modify-write stage on the distance memory.
  typedef struct packed {
    logic vld;    // stage holds an access
    logic init;   // initial load from the source row, else relaxation
    logic allow;  // entry may be updated (relax: not a self loop, not into source; init: source in range)
  } relax_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bfsp_if.sv
// Request and result channel interfaces of the shortest-path block.
`default_nettype none

interface bfsp_req_if;
  import bfsp_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [VTX_W-1:0]              row;
  logic [VTX_W-1:0]              col;
  logic signed [WEIGHT_IN_W-1:0] edge_weight;
  logic                          edge_present;
  logic [VTX_W-1:0]              src_vertex;

  modport source (output valid, cmd, row, col, edge_weight, edge_present, src_vertex,
                  input ready);
  modport sink   (input valid, cmd, row, col, edge_weight, edge_present, src_vertex,
                  output ready);
endinterface

interface bfsp_res_if;
  import bfsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [VTX_W-1:0]         vertex;
  logic signed [DIST_W-1:0] distance;
  logic                     reachable;
  logic                     last;

  modport source (output valid, vertex, distance, reachable, last, input ready);
  modport sink   (input valid, vertex, distance, reachable, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bfsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/bfsp_relax.sv
// Write stage of the distance memory: initial load and edge relaxation.
`default_nettype none

module bfsp_relax #(
  parameter int WEIGHT_BITS  = 16,
  parameter int MAX_VERTICES = 16
) (
  input  bfsp_pkg::relax_ctl_t                 ctl_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]      u_i,
  input  logic signed [bfsp_pkg::DIST_W-1:0]   di_i,
  input  logic [WEIGHT_BITS:0]                 wrd_i,
  input  logic [bfsp_pkg::DIST_W:0]            drd_i,
  output logic                                 we_o,
  output logic [$clog2(MAX_VERTICES)-1:0]      waddr_o,
  output logic [bfsp_pkg::DIST_W:0]            wdata_o
);
  import bfsp_pkg::*;

  localparam int SW = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 2;
  localparam logic signed [SW-1:0] HI = SW'((1 <<< (DIST_W - 1)) - 1);
  localparam logic signed [SW-1:0] LO = SW'(-(1 <<< (DIST_W - 1)));

  logic                     present;
  logic signed [SW-1:0]     w_ext;
  logic signed [SW-1:0]     di_ext;
  logic signed [SW-1:0]     sum;
  logic signed [DIST_W-1:0] cand;
  logic signed [DIST_W-1:0] du;
  logic                     ru;

  assign present = wrd_i[WEIGHT_BITS];
  assign w_ext   = {{(SW-WEIGHT_BITS){wrd_i[WEIGHT_BITS-1]}}, wrd_i[WEIGHT_BITS-1:0]};
  assign di_ext  = {{(SW-DIST_W){di_i[DIST_W-1]}}, di_i};
  assign sum     = ctl_i.init ? w_ext : (di_ext + w_ext);
  assign du      = drd_i[DIST_W-1:0];
  assign ru      = drd_i[DIST_W];

  always_comb begin
    if (sum > HI) begin
      cand = HI[DIST_W-1:0];
    end else if (sum < LO) begin
      cand = LO[DIST_W-1:0];
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  always_comb begin
    waddr_o = u_i;
    if (ctl_i.init) begin
      we_o    = ctl_i.vld;
      wdata_o = (ctl_i.allow && present) ? {1'b1, cand} : '0;
    end else begin
      we_o    = ctl_i.vld && ctl_i.allow && present && (!ru || (du > cand));
      wdata_o = {1'b1, cand};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bellman_ford_shortest_paths.sv
// Top level of the single-source shortest-path block (Bellman-Ford relaxation).
//
// Usage:
//  - req_i carries requests. cmd = write stores one adjacency entry (row, col,
//    edge_weight, edge_present); one write is taken per cycle while the block is idle. cmd = run starts
//    a search from vertex src_vertex over the first vertex_count vertices.
//  - cfg_we_i / cfg_wdata_i set vertex_count (clamped to 2..MAX_VERTICES when a
//    run starts). Write it only while the block is idle.
//  - res_o returns one result per vertex, 0 first, last set on the final one.
// Steps of a run with n vertices:
//  - initial load of the source row into the distances
//  - n - 2 passes; per vertex i: fetch d[i], then, if i is reached, a
//    pipelined read-modify-write over row i
//  - readout: each result is fetched from the distance RAM into the output register.
// The block is busy (req_i.ready low) from a run until its last result is in
// the output register; the final result may wait there while new requests are
// taken. A stalled receiver holds the output register and stops readout.
// Reset clears the sequencer, the output valid and sets vertex_count to 16;
// RAM contents are undefined until written.
`default_nettype none

module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfsp_pkg::VC_W-1:0] cfg_wdata_i,
  bfsp_req_if.sink                  req_i,
  bfsp_res_if.source                res_o
);
  import bfsp_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int IW = (VW > VTX_W) ? VW : VTX_W;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;  // stream source row into distances
  localparam logic [3:0] S_IDRN = 4'd2;  // last initial write lands
  localparam logic [3:0] S_RDI  = 4'd3;  // fetch d[i]
  localparam logic [3:0] S_LDI  = 4'd4;  // latch d[i]
  localparam logic [3:0] S_REL  = 4'd5;  // relax i->u, one u per cycle
  localparam logic [3:0] S_DRN  = 4'd6;  // last relax write lands
  localparam logic [3:0] S_EMIT = 4'd7;  // fetch d[u] once output slot frees
  localparam logic [3:0] S_ELD  = 4'd8;  // load output register

  logic [3:0]               state_q, state_d;
  logic [VC_W-1:0]          vc_q;
  logic [NW-1:0]            n_q, n_d;
  logic [VTX_W-1:0]         src_q, src_d;
  logic                     src_ok_q, src_ok_d;
  logic [VW-1:0]            u_q, u_d;
  logic [VW-1:0]            i_q, i_d;
  logic [VW-1:0]            pass_q, pass_d;
  logic signed [DIST_W-1:0] di_q, di_d;
  relax_ctl_t               p_ctl_q, p_ctl_d;
  logic [VW-1:0]            p_u_q, p_u_d;

  logic                     o_vld_q, o_vld_d;
  logic [VTX_W-1:0]         o_vtx_q, o_vtx_d;
  logic signed [DIST_W-1:0] o_dist_q, o_dist_d;
  logic                     o_reach_q, o_reach_d;
  logic                     o_last_q, o_last_d;

  // weight/edge RAM: {present, weight}
  logic                     w_we;
  logic [AW-1:0]            w_waddr;
  logic [WEIGHT_BITS:0]     w_wdata;
  logic [AW-1:0]            w_raddr;
  logic [WEIGHT_BITS:0]     w_rdata;
  // distance RAM: {reached, distance}
  logic                     d_we;
  logic [VW-1:0]            d_waddr;
  logic [DIST_W:0]          d_wdata;
  logic [VW-1:0]            d_raddr;
  logic [DIST_W:0]          d_rdata;

  logic                     req_acc;
  logic signed [31:0]       w32;
  logic                     u_last, i_last, pass_last;
  logic                     adv_i;
  int                       n_int;

  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // matrix writes go straight into the RAM
  assign w32     = {{(32-WEIGHT_IN_W){req_i.edge_weight[WEIGHT_IN_W-1]}}, req_i.edge_weight};
  assign w_we    = req_acc && (req_i.cmd == CMD_WRITE) &&
                   (int'(req_i.row) < MAX_VERTICES) && (int'(req_i.col) < MAX_VERTICES);
  assign w_waddr = AW'(int'(req_i.row) * MAX_VERTICES + int'(req_i.col));
  assign w_wdata = {req_i.edge_present, w32[WEIGHT_BITS-1:0]};

  assign u_last    = (u_q == VW'(int'(n_q) - 1));
  assign i_last    = (i_q == VW'(int'(n_q) - 1));
  assign pass_last = (pass_q == VW'(int'(n_q) - 3));

  // initial load reads the source row, relaxation reads row i
  assign w_raddr  = (state_q == S_INIT) ? AW'(int'(src_q) * MAX_VERTICES + int'(u_q))
                                        : AW'(int'(i_q) * MAX_VERTICES + int'(u_q));
  assign d_raddr  = (state_q == S_RDI) ? i_q : u_q;

  bfsp_ram #(
    .WIDTH (WEIGHT_BITS + 1),
    .DEPTH (MAX_VERTICES * MAX_VERTICES)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  bfsp_ram #(
    .WIDTH (DIST_W + 1),
    .DEPTH (MAX_VERTICES)
  ) u_dram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // second half of the read-modify-write; consecutive accesses hit distinct u,
  // and the DRN/IDRN bubble keeps the d[i] fetch behind the last write
  bfsp_relax #(
    .WEIGHT_BITS  (WEIGHT_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_relax (
    .ctl_i   (p_ctl_q),
    .u_i     (p_u_q),
    .di_i    (di_q),
    .wrd_i   (w_rdata),
    .drd_i   (d_rdata),
    .we_o    (d_we),
    .waddr_o (d_waddr),
    .wdata_o (d_wdata)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    src_d     = src_q;
    src_ok_d  = src_ok_q;
    u_d       = u_q;
    i_d       = i_q;
    pass_d    = pass_q;
    di_d      = di_q;
    p_ctl_d   = '0;
    p_u_d     = u_q;
    o_vld_d   = o_vld_q && !res_o.ready;
    o_vtx_d   = o_vtx_q;
    o_dist_d  = o_dist_q;
    o_reach_d = o_reach_q;
    o_last_d  = o_last_q;
    adv_i     = 1'b0;
    n_int     = int'(vc_q);
    if (n_int < 2) begin
      n_int = 2;
    end
    if (n_int > MAX_VERTICES) begin
      n_int = MAX_VERTICES;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc && (req_i.cmd == CMD_RUN)) begin
          n_d      = NW'(n_int);
          src_d    = req_i.src_vertex;
          src_ok_d = (int'(req_i.src_vertex) < MAX_VERTICES);
          u_d      = '0;
          state_d  = S_INIT;
        end
      end
      S_INIT: begin
        p_ctl_d = '{vld: 1'b1, init: 1'b1, allow: src_ok_q};
        if (u_last) begin
          state_d = S_IDRN;
        end else begin
          u_d = u_q + 1'b1;
        end
      end
      S_IDRN: begin
        pass_d = '0;
        i_d    = '0;
        u_d    = '0;
        state_d = (n_q == NW'(2)) ? S_EMIT : S_RDI;
      end
      S_RDI: begin
        state_d = S_LDI;
      end
      S_LDI: begin
        di_d = d_rdata[DIST_W-1:0];
        if (d_rdata[DIST_W]) begin
          u_d     = '0;
          state_d = S_REL;
        end else begin
          adv_i = 1'b1;
        end
      end
      S_REL: begin
        p_ctl_d = '{vld: 1'b1, init: 1'b0,
                    allow: (u_q != i_q) && (IW'(u_q) != IW'(src_q))};
        if (u_last) begin
          state_d = S_DRN;
        end else begin
          u_d = u_q + 1'b1;
        end
      end
      S_DRN: begin
        adv_i = 1'b1;
      end
      S_EMIT: begin
        if (!o_vld_q || res_o.ready) begin
          state_d = S_ELD;
        end
      end
      S_ELD: begin
        o_vld_d   = 1'b1;
        o_vtx_d   = VTX_W'(u_q);
        o_reach_d = d_rdata[DIST_W];
        o_dist_d  = d_rdata[DIST_W] ? d_rdata[DIST_W-1:0] : '0;
        o_last_d  = u_last;
        if (u_last) begin
          state_d = S_IDLE;
        end else begin
          u_d     = u_q + 1'b1;
          state_d = S_EMIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // next source vertex, next pass, or readout
    if (adv_i) begin
      if (i_last) begin
        i_d = '0;
        if (pass_last) begin
          u_d     = '0;
          state_d = S_EMIT;
        end else begin
          pass_d  = pass_q + 1'b1;
          state_d = S_RDI;
        end
      end else begin
        i_d     = i_q + 1'b1;
        state_d = S_RDI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vc_q    <= VC_RESET;
      pass_q  <= '0;
      p_ctl_q <= '0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      p_ctl_q <= p_ctl_d;
      o_vld_q <= o_vld_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    src_q     <= src_d;
    src_ok_q  <= src_ok_d;
    u_q       <= u_d;
    i_q       <= i_d;
    di_q      <= di_d;
    p_u_q     <= p_u_d;
    o_vtx_q   <= o_vtx_d;
    o_dist_q  <= o_dist_d;
    o_reach_q <= o_reach_d;
    o_last_q  <= o_last_d;
  end

  assign res_o.valid     = o_vld_q;
  assign res_o.vertex    = o_vtx_q;
  assign res_o.distance  = o_dist_q;
  assign res_o.reachable = o_reach_q;
  assign res_o.last      = o_last_q;

endmodule

`default_nettype wire

FILE: rtl/bfsp_checker.sv
// Port-level checker of the shortest-path block and its bind statement.
`default_nettype none

`include "bellman_ford_shortest_paths_assert.svh"

module bfsp_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfsp_req_if.sink   req_i,
  bfsp_res_if.source res_o
);
  import bfsp_pkg::*;

  // a stalled result stays offered
  `BFSP_ASSERT_NXT(a_res_hold, res_o.valid && !res_o.ready, res_o.valid, "result dropped while stalled")

  // unreachable vertices report distance zero
  `BFSP_ASSERT_IMP(a_unreach_zero, res_o.valid && !res_o.reachable, res_o.distance == '0, "unreachable vertex with nonzero distance")

  // a run request makes the block busy
  `BFSP_ASSERT_NXT(a_run_busy, req_i.valid && req_i.ready && (req_i.cmd == CMD_RUN), !req_i.ready, "request taken during a run")

  // no new request while a run still has results to produce
  `BFSP_ASSERT_IMP(a_emit_busy, res_o.valid && !res_o.last, !req_i.ready, "ready before last result")

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .res_o  (res_o)
);

`default_nettype wire
